@@ hdl/ppmfd_pkg.sv @@
// Shared types and constants for the PPM frame decoder.
package ppmfd_pkg;

    // Default configuration of the block
    localparam int CHANNEL_COUNT_DEF = 8;
    localparam int REPORT_AXES_DEF   = 4;
    localparam int TIMER_BITS_DEF    = 16;

    // Fixed field widths
    localparam int STAMP_W = 16;
    localparam int BYTE_W  = 8;

    // Reset value of the sync threshold register
    localparam logic [STAMP_W-1:0] SYNC_RESET = 16'd5000;

    // Pulse width window that maps onto the axis range
    localparam logic [STAMP_W-1:0] WIDTH_LOW  = 16'd950;
    localparam logic [STAMP_W-1:0] WIDTH_HIGH = 16'd1950;

    // floor(x * 254 / 1000) == (x * MAP_K) >> MAP_SHIFT for x in 0..1000
    localparam int               MAP_PROD_W = 35;
    localparam int               MAP_SHIFT  = 26;
    localparam logic [MAP_PROD_W-1:0] MAP_K = 35'd17045686;

    // Offset that centers the mapped axis on zero
    localparam logic [BYTE_W-1:0] AXIS_OFFSET = 8'd127;

    // Header byte at the start of every report
    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h00;

    typedef enum logic {
        KIND_CAPTURE = 1'b0,
        KIND_REPORT  = 1'b1
    } kind_t;

    // Capture beat handed from the input register to the timing logic
    typedef struct packed {
        logic               fire;
        logic [STAMP_W-1:0] stamp;
    } capture_beat_t;

endpackage

@@ hdl/ppmfd_capture.sv @@
// Pulse gap measurement, channel index and stored channel widths.
module ppmfd_capture #(
    parameter int CHANNEL_COUNT = ppmfd_pkg::CHANNEL_COUNT_DEF,
    parameter int TIMER_BITS    = ppmfd_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ppmfd_pkg::STAMP_W-1:0] cfg_data,
    input  ppmfd_pkg::capture_beat_t      beat,
    output logic [ppmfd_pkg::STAMP_W-1:0] widths [CHANNEL_COUNT]
);
    import ppmfd_pkg::*;

    localparam int DW    = (TIMER_BITS > STAMP_W) ? TIMER_BITS : STAMP_W;
    localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic [STAMP_W-1:0] thr_reg;
    logic [STAMP_W-1:0] prev_reg;
    logic [STAMP_W-1:0] prev_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [STAMP_W-1:0] widths_reg  [CHANNEL_COUNT];
    logic [STAMP_W-1:0] widths_next [CHANNEL_COUNT];

    logic [DW-1:0]         diff;
    logic [TIMER_BITS-1:0] gap;
    logic [DW-1:0]         gap_ext;
    logic                  is_sync;

    // Wrapped gap modulo the timer width
    assign diff    = DW'(beat.stamp) - DW'(prev_reg);
    assign gap     = diff[TIMER_BITS-1:0];
    assign gap_ext = DW'(gap);
    assign is_sync = gap_ext > DW'(thr_reg);

    always_comb
    begin
        prev_next = prev_reg;
        idx_next  = idx_reg;
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            widths_next[i] = widths_reg[i];
        end
        if (beat.fire)
        begin
            prev_next = beat.stamp;
            if (is_sync)
            begin
                idx_next = '0;
            end
            else
            begin
                for (int i = 0; i < CHANNEL_COUNT; i++)
                begin
                    if (idx_reg == IDX_W'(i))
                    begin
                        widths_next[i] = gap_ext[STAMP_W-1:0];
                    end
                end
                if (idx_reg == IDX_W'(CHANNEL_COUNT - 1))
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= SYNC_RESET;
            prev_reg <= '0;
            idx_reg  <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                widths_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                thr_reg <= cfg_data;
            end
            prev_reg <= prev_next;
            idx_reg  <= idx_next;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                widths_reg[i] <= widths_next[i];
            end
        end
    end

    assign widths = widths_reg;

endmodule

@@ hdl/ppmfd_axis_map.sv @@
// Clamp a pulse width and map it linearly onto a signed axis byte.
module ppmfd_axis_map (
    input  logic [ppmfd_pkg::STAMP_W-1:0] width,
    output logic [ppmfd_pkg::BYTE_W-1:0]  axis_byte
);
    import ppmfd_pkg::*;

    logic [STAMP_W-1:0]    clamped;
    logic [STAMP_W-1:0]    offset;
    logic [MAP_PROD_W-1:0] prod;
    logic [BYTE_W-1:0]     span;

    always_comb
    begin
        if (width < WIDTH_LOW)
        begin
            clamped = WIDTH_LOW;
        end
        else if (width > WIDTH_HIGH)
        begin
            clamped = WIDTH_HIGH;
        end
        else
        begin
            clamped = width;
        end
    end

    // offset is 0..1000, span is 0..254
    assign offset    = clamped - WIDTH_LOW;
    assign prod      = MAP_PROD_W'(offset) * MAP_K;
    assign span      = prod[MAP_SHIFT+BYTE_W-1:MAP_SHIFT];
    assign axis_byte = span - AXIS_OFFSET;

endmodule

@@ hdl/ppmfd_report_out.sv @@
// Report output buffer: holds one report and streams it a beat at a time.
module ppmfd_report_out #(
    parameter int REPORT_AXES = ppmfd_pkg::REPORT_AXES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [ppmfd_pkg::BYTE_W-1:0] axis_bytes [REPORT_AXES],
    input  logic                         out_stall,
    output logic                         load_ok,
    output logic                         out_valid,
    output logic [ppmfd_pkg::BYTE_W-1:0] report_byte,
    output logic                         last_byte
);
    import ppmfd_pkg::*;

    localparam int BEATS = REPORT_AXES + 1;
    localparam int CNT_W = $clog2(BEATS + 1);

    logic [BYTE_W-1:0] bytes_reg  [BEATS];
    logic [BYTE_W-1:0] bytes_next [BEATS];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              take;

    assign out_valid   = (cnt_reg != '0);
    assign last_byte   = (cnt_reg == CNT_W'(1));
    assign report_byte = bytes_reg[0];
    assign take        = out_valid && !out_stall;
    // Buffer is free when empty or when its last beat leaves this cycle
    assign load_ok     = !out_valid || (last_byte && !out_stall);

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < BEATS; i++)
        begin
            bytes_next[i] = bytes_reg[i];
        end
        if (load)
        begin
            cnt_next      = CNT_W'(BEATS);
            bytes_next[0] = HEADER_BYTE;
            for (int i = 0; i < REPORT_AXES; i++)
            begin
                bytes_next[i+1] = axis_bytes[i];
            end
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 1'b1;
            for (int i = 0; i < BEATS - 1; i++)
            begin
                bytes_next[i] = bytes_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BEATS; i++)
        begin
            bytes_reg[i] <= bytes_next[i];
        end
    end

endmodule

@@ hdl/ppm_frame_decoder.sv @@
// Top level of the PPM frame decoder.
//
// Input channel (in_valid / in_stall, kind, capture_time): a capture beat
// (kind 0) carries the timer stamp of one PPM edge; a report beat (kind 1)
// asks for one report. Beats land in an input register first.
// Captures stall only behind a waiting report; else one is accepted every
// cycle and updates the channel widths in the cycle after acceptance. A gap
// above sync_threshold restarts the channel index; any other gap is stored
// as the current channel width. Output channel (out_valid / out_stall,
// report_byte, last_byte): a report is 1 + REPORT_AXES beats, a zero header
// then the mapped axes, last_byte set on the final beat. The axes are
// snapshot when the report leaves the input register, so later captures do
// not disturb a report in flight. The header beat is shown once the report
// has passed the input register and been loaded into the output buffer, which
// holds one report and takes a new one only as its last beat leaves.
// When the receiver stalls, the buffer holds its beat; a waiting report then
// holds the input register and in_stall rises, while captures keep flowing
// until a report reaches the input register.
// Reset clears the stamp, the channel index, all widths (axes report -127)
// and loads sync_threshold with 5000. cfg_write loads sync_threshold.
module ppm_frame_decoder #(
    parameter int CHANNEL_COUNT = ppmfd_pkg::CHANNEL_COUNT_DEF,
    parameter int REPORT_AXES   = ppmfd_pkg::REPORT_AXES_DEF,
    parameter int TIMER_BITS    = ppmfd_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ppmfd_pkg::STAMP_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [ppmfd_pkg::STAMP_W-1:0] capture_time,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [ppmfd_pkg::BYTE_W-1:0] report_byte,
    output logic                          last_byte
);
    import ppmfd_pkg::*;

    // Input register
    logic               in_valid_reg;
    logic               in_valid_next;
    kind_t              kind_reg;
    kind_t              kind_next;
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;

    capture_beat_t      beat;
    logic [STAMP_W-1:0] widths     [CHANNEL_COUNT];
    logic [BYTE_W-1:0]  axis_bytes [REPORT_AXES];
    logic               load_ok;
    logic               load;
    logic [BYTE_W-1:0]  byte_out;

    // Hold a report in the input register until the buffer is free
    assign in_stall = in_valid_reg && (kind_reg == KIND_REPORT) && !load_ok;
    assign load     = in_valid_reg && (kind_reg == KIND_REPORT) && load_ok;

    assign beat = '{fire: in_valid_reg && (kind_reg == KIND_CAPTURE), stamp: stamp_reg};

    always_comb
    begin
        in_valid_next = in_valid_reg;
        kind_next     = kind_reg;
        stamp_next    = stamp_reg;
        if (!in_stall)
        begin
            in_valid_next = in_valid;
            kind_next     = kind_t'(kind);
            stamp_next    = capture_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        stamp_reg <= stamp_next;
    end

    ppmfd_capture #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .TIMER_BITS    (TIMER_BITS)
    ) u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .beat      (beat),
        .widths    (widths)
    );

    // One mapper per axis; an axis with no channel reads as width zero
    for (genvar k = 0; k < REPORT_AXES; k++)
    begin : g_axis
        logic [STAMP_W-1:0] axis_width;
        if (k < CHANNEL_COUNT)
        begin : g_chan
            assign axis_width = widths[k];
        end
        else
        begin : g_none
            assign axis_width = '0;
        end
        ppmfd_axis_map u_map (
            .width     (axis_width),
            .axis_byte (axis_bytes[k])
        );
    end

    ppmfd_report_out #(
        .REPORT_AXES (REPORT_AXES)
    ) u_report (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .axis_bytes  (axis_bytes),
        .out_stall   (out_stall),
        .load_ok     (load_ok),
        .out_valid   (out_valid),
        .report_byte (byte_out),
        .last_byte   (last_byte)
    );

    assign report_byte = $signed(byte_out);

endmodule

@@ hdl/ppmfd_checker.sv @@
// Port-level checks for the PPM frame decoder, bound to the top level.
module ppmfd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [ppmfd_pkg::BYTE_W-1:0]  report_byte,
    input logic                                 last_byte
);
    import ppmfd_pkg::*;

    // A stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(report_byte) && $stable(last_byte))
        else $error("stalled output beat changed");

    // Beats inside a report follow without gaps
    a_report_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_byte |=> out_valid)
        else $error("report broken before its last beat");

    // A report that follows straight on another opens with the header byte
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_byte |=>
            !out_valid || report_byte == $signed(HEADER_BYTE))
        else $error("report does not start with header byte");

    // Axis bytes stay within -127..127
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> report_byte != -8'sd128)
        else $error("report byte out of range");

endmodule

bind ppm_frame_decoder ppmfd_checker u_checker (.*);

@@ test/ppm_frame_decoder_tb.sv @@
// Self-checking testbench for the PPM frame decoder: random beats against an inline decoder model.
`timescale 1ns / 1ps

module ppm_frame_decoder_tb;

    import ppmfd_pkg::*;

    localparam int CHANNELS       = CHANNEL_COUNT_DEF;
    localparam int AXES           = REPORT_AXES_DEF;
    localparam int SETTLE_CYCLES  = 8;     // covers the capture write-back and report latency
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either channel
    localparam int SHOWN_ERRORS   = 10;

    // One input beat waiting for the driver. hold_for_drain keeps it back until
    // every expected report byte has been seen on the output.
    typedef struct {
        kind_t              kind;
        logic [STAMP_W-1:0] stamp;
        bit                 hold_for_drain;
    } ppm_beat_t;

    // One report byte the decoder owes us.
    typedef struct {
        logic signed [BYTE_W-1:0] value;
        logic                     last;
    } report_beat_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_write    = 1'b0;
    logic [STAMP_W-1:0]          cfg_data     = '0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic                        kind         = KIND_CAPTURE;
    logic [STAMP_W-1:0]          capture_time = '0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic signed [BYTE_W-1:0]    report_byte;
    logic                        last_byte;

    ppm_beat_t    pending_beats[$];
    report_beat_t report_bytes_due[$];

    // Decoder model state
    int                 sync_thr = int'(SYNC_RESET);
    logic [STAMP_W-1:0] last_stamp = '0;
    int                 chan_idx = 0;
    logic [STAMP_W-1:0] pulse_widths[CHANNELS];

    // Stimulus generator state: the last stamp queued for the block
    logic [STAMP_W-1:0] gen_stamp = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    ppm_frame_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .capture_time (capture_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .report_byte  (report_byte),
        .last_byte    (last_byte)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Clamp a pulse width into the stick window and scale it onto -127..127.
    function automatic logic signed [BYTE_W-1:0] axis_from_width(input int width);
        int lo;
        int hi;
        int w;
        lo = int'(WIDTH_LOW);
        hi = int'(WIDTH_HIGH);
        w  = width;
        if (w < lo) w = lo;
        if (w > hi) w = hi;
        return BYTE_W'((w - lo) * 2 * int'(AXIS_OFFSET) / (hi - lo) - int'(AXIS_OFFSET));
    endfunction

    // Advance the decoder model by one accepted input beat. A capture updates the
    // channel timing; a report queues the header and the mapped axes.
    task automatic decode_beat(input kind_t k, input logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0] gap;
        int                 w;
        if (k == KIND_CAPTURE)
        begin
            gap        = stamp - last_stamp;   // wraps modulo the timer width
            last_stamp = stamp;
            if (int'(gap) > sync_thr)
            begin
                chan_idx = 0;
            end
            else
            begin
                pulse_widths[chan_idx] = gap;
                chan_idx = (chan_idx == CHANNELS - 1) ? 0 : chan_idx + 1;
            end
        end
        else
        begin
            report_bytes_due.push_back('{HEADER_BYTE, AXES == 0});
            for (int a = 0; a < AXES; a++)
            begin
                w = (a < CHANNELS) ? int'(pulse_widths[a]) : 0;
                report_bytes_due.push_back('{axis_from_width(w), a == AXES - 1});
            end
        end
    endtask

    task automatic push_stamp(input logic [STAMP_W-1:0] stamp, input bit hold);
        gen_stamp = stamp;
        pending_beats.push_back('{KIND_CAPTURE, stamp, hold});
    endtask

    // Queue a capture that lands the given gap after the last queued stamp.
    task automatic push_gap(input int gap);
        push_stamp(gen_stamp + STAMP_W'(gap), 1'b0);
    endtask

    // Carry a random stamp on reports too: the block must ignore it.
    task automatic push_report(input bit hold);
        pending_beats.push_back('{KIND_REPORT, STAMP_W'($urandom), hold});
    endtask

    // Pick a pulse gap that stays at or below the sync threshold.
    function automatic int channel_gap();
        int g;
        case ($urandom_range(0, 9))
            0:       g = 0;
            1:       g = sync_thr;
            2:       g = $urandom_range(0, sync_thr);
            default: g = $urandom_range(900, 2000);
        endcase
        if (g > sync_thr) g = $urandom_range(0, sync_thr);
        return g;
    endfunction

    // Mostly well-formed frames (sync gap, a run of channel pulses, maybe a report)
    // with some stray stamps and lone reports mixed in.
    task automatic queue_random(input int count);
        int left;
        int pulses;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                if (sync_thr < 65535)
                begin
                    if ($urandom_range(0, 3) == 0)
                        push_gap(sync_thr + 1);
                    else
                        push_gap($urandom_range(sync_thr + 1, 65535));
                    left--;
                end
                pulses = $urandom_range(1, CHANNELS + 2);
                for (int p = 0; p < pulses; p++)
                    push_gap(channel_gap());
                left -= pulses;
                if ($urandom_range(0, 99) < 60)
                begin
                    push_report($urandom_range(0, 99) < 3);
                    left--;
                end
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    push_stamp(STAMP_W'($urandom), 1'b0);
                else
                    push_report($urandom_range(0, 99) < 3);
                left--;
            end
        end
    endtask

    // Wait until the block has taken every beat and returned every report byte,
    // then let in-flight captures land before touching the register.
    task automatic wait_drain();
        while (pending_beats.size() != 0 || in_valid || report_bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_threshold(input logic [STAMP_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sync_thr = value;
    endtask

    task automatic run_phase(input int thr, input int s_idle, input int r_stall,
                             input int count);
        wait_drain();
        load_threshold(STAMP_W'(thr));
        send_idle_pct = s_idle;
        stall_pct     = r_stall;
        queue_random(count);
    endtask

    // Driver: present the next pending beat whenever the channel slot is free.
    // Hold the payload while stalled; scramble it while valid is low.
    always @(posedge clk or negedge rst_n)
    begin : beat_driver
        ppm_beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_beat(kind_t'(kind), capture_time);
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() != 0
                    && !(pending_beats[0].hold_for_drain && report_bytes_due.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_beats.pop_front();
                    in_valid     <= 1'b1;
                    kind         <= nxt.kind;
                    capture_time <= nxt.stamp;
                end
                else
                begin
                    in_valid     <= 1'b0;
                    kind         <= 1'($urandom_range(0, 1));
                    capture_time <= STAMP_W'($urandom);
                end
            end
        end
    end

    // Monitor: check each accepted report byte against the oldest one due, then
    // pick the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin : report_monitor
        report_beat_t due;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (report_bytes_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS)
                        $display("unexpected report beat: byte %0d last %0b",
                                 report_byte, last_byte);
                end
                else
                begin
                    due = report_bytes_due.pop_front();
                    if (report_byte !== due.value || last_byte !== due.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_ERRORS)
                            $display("beat mismatch: byte exp %0d got %0d, last exp %0b got %0b",
                                     due.value, report_byte, due.last, last_byte);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        for (int c = 0; c < CHANNELS; c++)
            pulse_widths[c] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frame at the reset threshold, no idling.
        push_report(1'b0);               // widths still cleared: every axis at its floor
        push_stamp(16'hFFFF, 1'b0);      // top stamp, huge gap from reset: sync
        push_gap(950);                   // stamp wraps through zero; bottom of window
        push_gap(1950);                  // top of window
        push_gap(0);                     // zero gap stored as a width
        push_gap(2500);                  // above the window: clamps high
        push_report(1'b0);
        push_gap(949);                   // just under the window: clamps low
        push_gap(5000);                  // equal to threshold: still a pulse
        push_gap(5001);                  // one past threshold: sync, restart at channel 0
        push_gap(1951);
        push_gap(1000);
        push_gap(1500);
        push_gap(1499);
        push_report(1'b1);               // hold off until the previous report is out
        push_gap(1);
        push_gap(100);
        push_gap(4999);
        push_gap(2000);
        push_gap(1200);                  // ninth pulse wraps onto channel 0
        push_report(1'b0);
        push_stamp(16'h0000, 1'b0);
        push_report(1'b0);
        queue_random(40);

        run_phase(65535, 79, 0, 60);     // no gap can be sync
        run_phase(0, 0, 79, 60);         // only a zero gap is a pulse
        run_phase(2500, 37, 37, 60);
        run_phase($urandom_range(0, 65535), 0, 0, 60);
        run_phase(1800, 0, 79, 60);

        wait_drain();
        if (mismatch_count == 0 && report_bytes_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
